/* hw/rtl/mrfc_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the Modbus RTU frame checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mrfc_pkg;

    localparam int unsigned MIN_FRAME_BYTES = 4;

    localparam logic [15:0] CRC_START = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [8:0]  COUNT_MAX = 9'd511;
    localparam logic [8:0]  LEN_LIMIT = 9'd255;
    localparam logic [8:0]  MIN_COUNT = 9'(MIN_FRAME_BYTES);
    localparam logic [7:0]  BCAST_ADDR = 8'h00;
    localparam logic [7:0]  OWN_ADDR_RESET = 8'h01;

    localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
    localparam logic [2:0] VERDICT_TOO_SHORT = 3'd1;
    localparam logic [2:0] VERDICT_ADDR_MISS = 3'd2;
    localparam logic [2:0] VERDICT_CRC_BAD   = 3'd3;
    localparam logic [2:0] VERDICT_TOO_LONG  = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_byte_word;

    typedef struct packed {
        logic [2:0] verdict;
        logic [7:0] frame_address;
        logic [7:0] frame_length;
    } t_result;

    // Reflected CRC-16 update over one byte, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

/* hw/rtl/mrfc_in_stage.sv */
// Input register of the frame checker: takes one byte word per cycle while not stalled.
// Depends on mrfc_pkg for the word type.
`timescale 1ns / 1ps

module mrfc_in_stage import mrfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_byte_word i_word,
    input  logic       i_out_free,
    output logic       o_advance,
    output t_byte_word o_word
);

    logic       r_valid;
    t_byte_word r_word;
    logic       advance;
    logic       take;

    // A final byte needs room in the result register; other bytes always drain.
    assign advance    = r_valid && (!r_word.frame_end || i_out_free);
    assign take       = !r_valid || advance;
    assign o_in_stall = !take;
    assign o_advance  = advance;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in_valid) begin
            r_word <= i_word;
        end
    end

endmodule

/* hw/rtl/mrfc_frame_eval.sv */
// Frame state (CRC, two-byte delay, count, address) and the verdict logic.
// Depends on mrfc_pkg for the CRC function, constants and word types.
`timescale 1ns / 1ps

module mrfc_frame_eval import mrfc_pkg::*; #(
    parameter int unsigned MIN_BYTES = MIN_FRAME_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  t_byte_word i_word,
    input  logic [7:0] i_own_address,
    output t_result    o_result
);

    localparam logic [8:0] MIN_CNT = 9'(MIN_BYTES);

    logic [15:0] r_crc;
    logic [7:0]  r_older;
    logic [7:0]  r_newer;
    logic [8:0]  r_count;
    logic [7:0]  r_address;

    logic [15:0] n_crc;
    logic [7:0]  n_address;
    logic [8:0]  n_count;
    logic [15:0] stored_crc;
    logic [2:0]  verdict;

    always_comb begin
        n_address  = (r_count == 9'd0) ? i_word.rx_byte : r_address;
        n_crc      = (r_count >= 9'd2) ? crc16_byte(r_crc, r_older) : r_crc;
        n_count    = (r_count < COUNT_MAX) ? r_count + 9'd1 : r_count;
        stored_crc = {i_word.rx_byte, r_newer};

        if (n_count > LEN_LIMIT) begin
            verdict = VERDICT_TOO_LONG;
        end else if (n_count < MIN_CNT) begin
            verdict = VERDICT_TOO_SHORT;
        end else if (n_address != BCAST_ADDR && n_address != i_own_address) begin
            verdict = VERDICT_ADDR_MISS;
        end else if (n_crc != stored_crc) begin
            verdict = VERDICT_CRC_BAD;
        end else begin
            verdict = VERDICT_ACCEPT;
        end
    end

    assign o_result.verdict       = verdict;
    assign o_result.frame_address = n_address;
    assign o_result.frame_length  = (n_count > LEN_LIMIT) ? 8'hFF : n_count[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= CRC_START;
            r_older   <= 8'h00;
            r_newer   <= 8'h00;
            r_count   <= 9'd0;
            r_address <= 8'h00;
        end else if (i_advance) begin
            if (i_word.frame_end) begin
                // drop the frame, start over
                r_crc     <= CRC_START;
                r_older   <= 8'h00;
                r_newer   <= 8'h00;
                r_count   <= 9'd0;
                r_address <= 8'h00;
            end else begin
                r_crc     <= n_crc;
                r_older   <= r_newer;
                r_newer   <= i_word.rx_byte;
                r_count   <= n_count;
                r_address <= n_address;
            end
        end
    end

endmodule

/* hw/rtl/mrfc_out_stage.sv */
// Result register of the frame checker; holds a verdict word while the receiver stalls.
// Depends on mrfc_pkg for the result type.
`timescale 1ns / 1ps

module mrfc_out_stage import mrfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_out_stall,
    output logic    o_free,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;
    logic    free;

    assign free        = !r_valid || !i_out_stall;
    assign o_free      = free;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* hw/rtl/modbus_rtu_frame_checker_unit.sv */
// Top level of the Modbus RTU frame checker.
// Depends on mrfc_pkg, mrfc_in_stage, mrfc_frame_eval and mrfc_out_stage.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_stall): one frame byte per word, i_frame_end
//   set on the last byte of a frame. A running CRC-16 (0xA001 reflected, seed
//   0xFFFF) covers all bytes but the last two, which carry the CRC low byte first.
//   Output channel (o_out_valid / i_out_stall): one verdict word per frame,
//   with the address byte and the length (saturating at 255).
//   Config channel (i_cfg_valid / o_cfg_ready): writes the own slave address;
//   always ready, write it only while no frame is in flight.
//   Throughput: one byte per cycle while o_in_stall is low. The only per-byte work is an eight-step
//   CRC update between the input register and the frame state registers.
//   A final byte passes the input register; its verdict then loads the result register.
//   Reset (synchronous, active low) empties both registers, clears the frame
//   state and sets the own address to 1.
//   When the receiver stalls, the verdict holds; data bytes keep flowing and
//   only the next final byte waits in the input register, raising o_in_stall.
module modbus_rtu_frame_checker_unit import mrfc_pkg::*; #(
    parameter int unsigned MIN_BYTES = MIN_FRAME_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_verdict,
    output logic [7:0] o_frame_address,
    output logic [7:0] o_frame_length,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam logic [7:0] MIN_LENGTH = 8'(MIN_BYTES);

    logic [7:0] r_own_address;
    t_byte_word in_word;
    t_byte_word stage_word;
    t_result    eval_result;
    t_result    out_result;
    logic       advance;
    logic       out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= OWN_ADDR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_own_address <= i_cfg_data;
        end
    end

    assign in_word.rx_byte   = i_rx_byte;
    assign in_word.frame_end = i_frame_end;

    mrfc_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_word     (in_word),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_word     (stage_word)
    );

    mrfc_frame_eval #(
        .MIN_BYTES (MIN_BYTES)
    ) u_frame_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_word        (stage_word),
        .i_own_address (r_own_address),
        .o_result      (eval_result)
    );

    mrfc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && stage_word.frame_end),
        .i_result    (eval_result),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_verdict       = out_result.verdict;
    assign o_frame_address = out_result.frame_address;
    assign o_frame_length  = out_result.frame_length;

    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_only_on_blocked_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while result register could drain");

    a_too_long_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict == VERDICT_TOO_LONG) |-> (o_frame_length == 8'hFF))
        else $error("too-long verdict without saturated length");

    a_short_frame_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_length < MIN_LENGTH) |-> (o_verdict == VERDICT_TOO_SHORT))
        else $error("short frame not flagged too short");

endmodule

/* tb/frame_verdict_tb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the Modbus RTU frame checker: tracks CRC, held bytes and length per frame,
// and queues one expected verdict word per final byte.
// Depends on mrfc_pkg for the result type, CRC constants and verdict codes.

package frame_verdict_tb_pkg;
    import mrfc_pkg::*;

    class frame_verdict_board;
        logic [7:0]  own_addr;
        logic [15:0] crc_acc;
        logic [7:0]  older_byte;
        logic [7:0]  newer_byte;
        logic [8:0]  byte_cnt;
        logic [7:0]  addr_byte;
        t_result     verdict_q[$];
        int          mismatches;

        function new();
            own_addr   = OWN_ADDR_RESET;
            mismatches = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            crc_acc    = CRC_START;
            older_byte = 8'h00;
            newer_byte = 8'h00;
            byte_cnt   = 9'd0;
            addr_byte  = 8'h00;
        endfunction

        // Bitwise form: feed each data bit into the LSB feedback.
        static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ data[i];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function void set_own_address(logic [7:0] addr);
            own_addr = addr;
        endfunction

        function int waiting();
            return verdict_q.size();
        endfunction

        function void note_word(logic [7:0] rx, logic fe);
            t_result r;
            if (byte_cnt == 9'd0) begin
                addr_byte = rx;
            end
            // The two newest bytes stay out of the CRC until the frame ends.
            if (byte_cnt >= 9'd2) begin
                crc_acc = crc_update(crc_acc, older_byte);
            end
            older_byte = newer_byte;
            newer_byte = rx;
            if (byte_cnt != COUNT_MAX) begin
                byte_cnt++;
            end
            if (fe) begin
                r.frame_address = addr_byte;
                r.frame_length  = (byte_cnt > LEN_LIMIT) ? LEN_LIMIT[7:0] : byte_cnt[7:0];
                if (byte_cnt > LEN_LIMIT) begin
                    r.verdict = VERDICT_TOO_LONG;
                end else if (byte_cnt < MIN_COUNT) begin
                    r.verdict = VERDICT_TOO_SHORT;
                end else if (addr_byte != BCAST_ADDR && addr_byte != own_addr) begin
                    r.verdict = VERDICT_ADDR_MISS;
                end else if (crc_acc != {newer_byte, older_byte}) begin
                    r.verdict = VERDICT_CRC_BAD;
                end else begin
                    r.verdict = VERDICT_ACCEPT;
                end
                verdict_q.push_back(r);
                restart_frame();
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected verdict word: verdict %0d address %0d length %0d",
                         $time, got.verdict, got.frame_address, got.frame_length);
                mismatches++;
                return;
            end
            want = verdict_q.pop_front();
            if (got.verdict !== want.verdict) begin
                $display("%0t: verdict expected %0d actual %0d",
                         $time, want.verdict, got.verdict);
                mismatches++;
            end
            if (got.frame_address !== want.frame_address) begin
                $display("%0t: frame address expected %0d actual %0d",
                         $time, want.frame_address, got.frame_address);
                mismatches++;
            end
            if (got.frame_length !== want.frame_length) begin
                $display("%0t: frame length expected %0d actual %0d",
                         $time, want.frame_length, got.frame_length);
                mismatches++;
            end
        endfunction
    endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the frame checker testbench: clock, reset, frame stimulus, receiver and watchdog.
// Depends on mrfc_pkg, frame_verdict_tb_pkg and modbus_rtu_frame_checker_unit.

module tb_top;
    import mrfc_pkg::*;
    import frame_verdict_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_WORDS    = 24;
    localparam int NUM_PHASES     = 8;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_frame_end = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_verdict;
    logic [7:0] o_frame_address;
    logic [7:0] o_frame_length;
    logic       o_cfg_ready;

    frame_verdict_board board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int words_sent     = 0;

    modbus_rtu_frame_checker_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .i_frame_end     (i_frame_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_verdict       (o_verdict),
        .o_frame_address (o_frame_address),
        .o_frame_length  (o_frame_length),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: check accepted verdict words, then pick next cycle's stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_result({o_verdict, o_frame_address, o_frame_length});
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(logic [7:0] b, logic fe);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_rx_byte   <= b;
        i_frame_end <= fe;
        do @(posedge i_clk); while (o_in_stall);
        board.note_word(b, fe);
        words_sent++;
    endtask

    // Address first, random body, CRC low byte then high byte; a bad CRC flips bits in one.
    task automatic send_frame(int len, logic [7:0] addr, bit crc_ok);
        logic [15:0] crc;
        logic [7:0]  b;
        logic [7:0]  lo_flip;
        logic [7:0]  hi_flip;
        crc     = CRC_START;
        lo_flip = 8'h00;
        hi_flip = 8'h00;
        if (!crc_ok) begin
            if ($urandom_range(0, 1) == 0) begin
                lo_flip = 8'($urandom_range(1, 255));
            end else begin
                hi_flip = 8'($urandom_range(1, 255));
            end
        end
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                b = addr;
            end else if (len >= 3 && i == len - 2) begin
                b = crc[7:0] ^ lo_flip;
            end else if (len >= 3 && i == len - 1) begin
                b = crc[15:8] ^ hi_flip;
            end else begin
                b = 8'($urandom);
            end
            if (i < len - 2) begin
                crc = frame_verdict_board::crc_update(crc, b);
            end
            send_word(b, i == len - 1);
        end
    endtask

    // Mostly in-range frames, for the current, broadcast or a random address; some short or long.
    task automatic random_frame();
        int         pick;
        int         len;
        logic [7:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            len = $urandom_range(MIN_FRAME_BYTES, 12);
        end else if (pick < 85) begin
            len = $urandom_range(1, MIN_FRAME_BYTES - 1);
        end else begin
            len = $urandom_range(13, 40);
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            addr = board.own_addr;
        end else if (pick < 65) begin
            addr = BCAST_ADDR;
        end else begin
            addr = 8'($urandom);
        end
        send_frame(len, addr, $urandom_range(0, 99) < 75);
    endtask

    // Drop valid, wait for every verdict, then let the pipeline drain.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.waiting() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_own_address(logic [7:0] addr);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_own_address(addr);
    endtask

    initial begin
        int         phase_start;
        logic [7:0] addr;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames against the reset address.
        send_frame(1, 8'hFF, 1'b1);
        send_frame(2, BCAST_ADDR, 1'b1);
        send_frame(MIN_FRAME_BYTES - 1, OWN_ADDR_RESET, 1'b1);
        send_frame(MIN_FRAME_BYTES, OWN_ADDR_RESET, 1'b1);
        send_frame(MIN_FRAME_BYTES, BCAST_ADDR, 1'b1);
        send_frame(MIN_FRAME_BYTES, 8'h02, 1'b1);
        send_frame(MIN_FRAME_BYTES + 1, OWN_ADDR_RESET, 1'b0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: addr = 8'd247;
                1: addr = 8'd0;
                2: addr = 8'd255;
                3: addr = 8'd1;
                default: addr = 8'($urandom_range(1, 247));
            endcase
            write_own_address(addr);
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default: begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            // Hold the receiver off while bytes keep coming, so the input backs up.
            if (ph == 0) begin
                hold_request = 1'b1;
            end
            // Longest frame that is still in range, and two bytes past the counter's saturation.
            if (ph == 1) begin
                send_frame(255, board.own_addr, 1'b1);
            end
            if (ph == 5) begin
                send_frame(513, 8'($urandom), $urandom_range(0, 1) == 1);
            end
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                random_frame();
            end
        end

        settle();
        if (board.mismatches == 0 && board.waiting() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
